@@ design/edf_scheduler_with_precedence_defines.svh @@
// assertion macros for the edf scheduler checker
// no dependencies
`ifndef EDF_SCHEDULER_WITH_PRECEDENCE_DEFINES_SVH
`define EDF_SCHEDULER_WITH_PRECEDENCE_DEFINES_SVH

// same-cycle implication
`define EDFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define EDFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/edfs_pkg.sv @@
// shared constants and types for the edf scheduler
// no dependencies
package edfs_pkg;
	localparam int MAX_JOBS = 16;
	localparam int IDX_W    = $clog2(MAX_JOBS);
	localparam int CNT_W    = IDX_W + 1;
	localparam int TIME_W   = 16;
	localparam int WORK_W   = 15;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [CNT_W-1:0]  NO_JOB   = CNT_W'(MAX_JOBS);

	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_PREPARE = 2'd1;
	localparam logic [1:0] CMD_TICK    = 2'd2;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	typedef struct packed {
		logic [TIME_W-1:0]        rel;
		logic signed [15:0]       due;
		logic [WORK_W-1:0]        work;
		logic [WORK_W-1:0]        rem;
		logic [MAX_JOBS-1:0]      pred;
	} job_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		job_t             data;
	} mem_wr_t;

	typedef struct packed {
		logic              ran_valid;
		logic [IDX_W-1:0]  ran_job;
		logic              segment_start;
		logic              job_finished;
		logic [TIME_W-1:0] finish_at;
	} res_t;
endpackage

@@ design/edfs_if.sv @@
// valid/ready channels for items, results and configuration
// depends on nothing
interface edfs_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [3:0]  job_slot;
	logic [14:0] release_time;
	logic [14:0] work_ticks;
	logic signed [15:0] due_time;
	logic [15:0] predecessor_mask;
	modport source(output valid, cmd, job_slot, release_time, work_ticks, due_time,
		predecessor_mask, input ready);
	modport sink(input valid, cmd, job_slot, release_time, work_ticks, due_time,
		predecessor_mask, output ready);
endinterface

interface edfs_result_if;
	logic        valid;
	logic        ready;
	logic        ran_valid;
	logic [3:0]  ran_job;
	logic        segment_start;
	logic        job_finished;
	logic [15:0] finish_at;
	logic        all_done;
	logic [15:0] now_time;
	modport source(output valid, ran_valid, ran_job, segment_start, job_finished,
		finish_at, all_done, now_time, input ready);
	modport sink(input valid, ran_valid, ran_job, segment_start, job_finished,
		finish_at, all_done, now_time, output ready);
endinterface

interface edfs_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

@@ design/edfs_job_mem.sv @@
// job table memory, one write port, one registered read port
// depends on edfs_pkg
module edfs_job_mem (
	input  logic                          clk,
	input  logic [edfs_pkg::IDX_W-1:0]    rd_addr,
	input  edfs_pkg::mem_wr_t             wr,
	output edfs_pkg::job_t                rd_data
);
	edfs_pkg::job_t mem_q [edfs_pkg::MAX_JOBS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

@@ design/edf_scheduler_with_precedence.sv @@
// edf scheduler with precedence, top level
// depends on edfs_pkg, edfs_if, edfs_job_mem
// Every item gives one result. The job table sits in a single memory with a registered read,
// so all work is a walk over its entries with n = min(job_count, 16). A load or an unused
// command goes straight to its result. A tick does one memory read per entry to find the
// earliest ready deadline, then one write back of the chosen job (a tick with everything
// finished goes straight to its result). A prepare runs a forward and a backward precedence
// pass; each visit of an entry reads it and, unless the entry is skipped, rescans all n
// entries; passes repeat until nothing changes (at most n + 1 per direction), and a final
// sweep reloads the remaining work of all 16 entries. Items are taken while a result still
// waits.
module edf_scheduler_with_precedence (
	input  logic           clk,
	input  logic           arst_n,
	edfs_cfg_if.sink       cfg,
	edfs_item_if.sink      items,
	edfs_result_if.source  results
);
	typedef enum logic [3:0] {
		S_IDLE, S_TSCAN, S_TFIN, S_PRD, S_PGOT, S_PSCAN, S_PWR, S_SWEEP, S_OUT
	} state_t;

	localparam int IW = edfs_pkg::IDX_W;
	localparam int CW = edfs_pkg::CNT_W;
	localparam int NJ = edfs_pkg::MAX_JOBS;
	localparam int TW = edfs_pkg::TIME_W;

	state_t                 state_q;
	logic [CW-1:0]          job_count_q;
	logic [TW-1:0]          clock_q;
	logic [TW-1:0]          now_q;
	logic [CW-1:0]          prev_q;
	logic [NJ-1:0]          nz_q;
	logic [NJ-1:0]          done_q;
	logic                   moved_q;
	logic                   back_q;
	logic [IW-1:0]          pi_q;
	logic [CW-1:0]          scan_q;
	logic                   vld_s1;
	logic [IW-1:0]          idx_s1;
	logic                   abort_q;
	logic [15:0]            acc_q;
	logic                   found_q;
	logic [IW-1:0]          pick_q;
	edfs_pkg::job_t         cur_q;
	edfs_pkg::job_t         best_q;
	edfs_pkg::res_t         res_q;
	edfs_pkg::res_t         out_q;
	logic                   out_valid_q;
	logic                   out_done_q;
	logic [TW-1:0]          out_now_q;

	logic [CW-1:0]          n_jobs;
	logic [NJ-1:0]          use_m;
	logic [CW-1:0]          lim;
	logic                   issue;
	logic                   scan_end;
	logic                   last_i;
	logic                   skip_i;
	logic                   step_i;
	logic                   mv;
	logic                   cand;
	logic                   accept;
	logic [IW-1:0]          rd_addr;
	edfs_pkg::mem_wr_t      wr;
	edfs_pkg::job_t         rd;
	logic [TW:0]            fsum;
	logic [TW-1:0]          fsat;
	logic signed [16:0]     bdif;
	logic signed [15:0]     bsat;
	logic [TW-1:0]          clock_inc;
	edfs_pkg::job_t         load_rec;

	edfs_job_mem u_mem (.clk(clk), .rd_addr(rd_addr), .wr(wr), .rd_data(rd));

	assign n_jobs    = (job_count_q > CW'(NJ)) ? CW'(NJ) : job_count_q;
	assign use_m     = NJ'(({{NJ{1'b0}}, 1'b1} << n_jobs) - {{NJ{1'b0}}, 1'b1});
	assign lim       = (state_q == S_SWEEP) ? CW'(NJ) : n_jobs;
	assign issue     = (scan_q < lim);
	assign scan_end  = !issue && !vld_s1;
	assign last_i    = ({1'b0, pi_q} == n_jobs - CW'(1));
	assign skip_i    = done_q[pi_q] || (!back_q && ((rd.pred & use_m & ~done_q) != '0));
	assign step_i    = ((state_q == S_PGOT) && skip_i) || (state_q == S_PWR);
	assign mv        = (state_q == S_PWR) ? (moved_q || !abort_q) : moved_q;
	assign accept    = items.valid && items.ready;
	assign clock_inc = (clock_q == edfs_pkg::TIME_MAX) ? clock_q : clock_q + TW'(1);

	assign fsum = {1'b0, rd.rel} + {{(TW + 1 - edfs_pkg::WORK_W){1'b0}}, rd.work};
	assign fsat = fsum[TW] ? edfs_pkg::TIME_MAX : fsum[TW-1:0];
	assign bdif = {rd.due[15], rd.due} - $signed({2'b00, rd.work});
	assign bsat = (bdif < -17'sd32768) ? -16'sd32768 : bdif[15:0];
	assign cand = (rd.rem != '0) && (rd.rel <= clock_q) &&
		(!found_q || (rd.due < best_q.due));

	assign items.ready = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;

	always_comb begin
		load_rec.rel  = {1'b0, items.release_time};
		load_rec.due  = items.due_time;
		load_rec.work = items.work_ticks;
		load_rec.rem  = items.work_ticks;
		load_rec.pred = items.predecessor_mask;
	end

	always_comb begin
		rd_addr = scan_q[IW-1:0];
		if (state_q == S_PRD) begin
			rd_addr = pi_q;
		end
	end

	always_comb begin
		wr.en   = 1'b0;
		wr.addr = idx_s1;
		wr.data = rd;
		unique case (state_q)
			S_IDLE: begin
				wr.en   = accept && (items.cmd == edfs_pkg::CMD_LOAD);
				wr.addr = items.job_slot;
				wr.data = load_rec;
			end
			S_SWEEP: begin
				wr.en       = vld_s1;
				wr.data.rem = rd.work;
			end
			S_TFIN: begin
				wr.en       = found_q;
				wr.addr     = pick_q;
				wr.data     = best_q;
				wr.data.rem = best_q.rem - edfs_pkg::WORK_W'(1);
			end
			S_PWR: begin
				wr.en   = !abort_q;
				wr.addr = pi_q;
				wr.data = cur_q;
				if (back_q) begin
					wr.data.due = acc_q;
				end else begin
					wr.data.rel = acc_q;
				end
			end
			default: begin
				wr.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			job_count_q <= '0;
			clock_q     <= '0;
			prev_q      <= edfs_pkg::NO_JOB;
			nz_q        <= '0;
			done_q      <= '0;
			moved_q     <= 1'b0;
			back_q      <= 1'b0;
			pi_q        <= '0;
			scan_q      <= '0;
			vld_s1      <= 1'b0;
			abort_q     <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				job_count_q <= cfg.data;
			end
			if (out_valid_q && results.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_TSCAN || state_q == S_PSCAN || state_q == S_SWEEP) begin
				vld_s1 <= issue;
				idx_s1 <= scan_q[IW-1:0];
				if (issue) begin
					scan_q <= scan_q + CW'(1);
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q  <= '0;
						now_q  <= clock_q;
						scan_q <= '0;
						vld_s1 <= 1'b0;
						if (items.cmd == edfs_pkg::CMD_LOAD) begin
							nz_q[items.job_slot] <= (items.work_ticks != '0);
							state_q <= S_OUT;
						end else if (items.cmd == edfs_pkg::CMD_PREPARE) begin
							done_q  <= '0;
							moved_q <= 1'b0;
							back_q  <= 1'b0;
							pi_q    <= '0;
							state_q <= (n_jobs == '0) ? S_SWEEP : S_PRD;
						end else if (items.cmd == edfs_pkg::CMD_TICK) begin
							found_q <= 1'b0;
							state_q <= ((nz_q & use_m) != '0) ? S_TSCAN : S_OUT;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_TSCAN: begin
					if (vld_s1 && cand) begin
						found_q <= 1'b1;
						best_q  <= rd;
						pick_q  <= idx_s1;
					end
					if (scan_end) begin
						state_q <= S_TFIN;
					end
				end
				S_TFIN: begin
					if (!found_q) begin
						prev_q <= edfs_pkg::NO_JOB;
					end else begin
						res_q.ran_valid     <= 1'b1;
						res_q.ran_job       <= pick_q;
						res_q.segment_start <= ({1'b0, pick_q} != prev_q);
						res_q.job_finished  <= (best_q.rem == edfs_pkg::WORK_W'(1));
						res_q.finish_at     <= (best_q.rem == edfs_pkg::WORK_W'(1)) ?
							clock_inc : '0;
						prev_q       <= {1'b0, pick_q};
						nz_q[pick_q] <= (best_q.rem != edfs_pkg::WORK_W'(1));
					end
					clock_q <= clock_inc;
					state_q <= S_OUT;
				end
				S_PRD: begin
					state_q <= S_PGOT;
				end
				S_PGOT: begin
					cur_q   <= rd;
					acc_q   <= back_q ? rd.due : rd.rel;
					abort_q <= 1'b0;
					if (!skip_i) begin
						scan_q  <= '0;
						vld_s1  <= 1'b0;
						state_q <= S_PSCAN;
					end
				end
				S_PSCAN: begin
					if (vld_s1) begin
						if (!back_q) begin
							if (cur_q.pred[idx_s1] && (fsat > acc_q)) begin
								acc_q <= fsat;
							end
						end else if (rd.pred[pi_q]) begin
							if (!done_q[idx_s1]) begin
								abort_q <= 1'b1;
							end else if (bsat < $signed(acc_q)) begin
								acc_q <= bsat;
							end
						end
					end
					if (scan_end) begin
						state_q <= S_PWR;
					end
				end
				S_PWR: begin
					if (!abort_q) begin
						done_q[pi_q] <= 1'b1;
					end
				end
				S_SWEEP: begin
					if (vld_s1) begin
						nz_q[idx_s1] <= (rd.work != '0);
					end
					if (scan_end) begin
						clock_q <= '0;
						now_q   <= '0;
						prev_q  <= edfs_pkg::NO_JOB;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || results.ready) begin
						out_valid_q <= 1'b1;
						out_q       <= res_q;
						out_done_q  <= ((nz_q & use_m) == '0);
						out_now_q   <= now_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (step_i) begin
				state_q <= S_PRD;
				if (last_i) begin
					pi_q    <= '0;
					moved_q <= 1'b0;
					if (!mv) begin
						if (!back_q) begin
							back_q <= 1'b1;
							done_q <= '0;
						end else begin
							scan_q  <= '0;
							vld_s1  <= 1'b0;
							state_q <= S_SWEEP;
						end
					end
				end else begin
					pi_q    <= pi_q + IW'(1);
					moved_q <= mv;
				end
			end
		end
	end

	assign results.valid         = out_valid_q;
	assign results.ran_valid     = out_q.ran_valid;
	assign results.ran_job       = out_q.ran_job;
	assign results.segment_start = out_q.segment_start;
	assign results.job_finished  = out_q.job_finished;
	assign results.finish_at     = out_q.finish_at;
	assign results.all_done      = out_done_q;
	assign results.now_time      = out_now_q;
endmodule

@@ design/edfs_checker.sv @@
// port-level checks on the edf scheduler results, bound to the top level
// depends on edf_scheduler_with_precedence_defines.svh
`include "edf_scheduler_with_precedence_defines.svh"

module edfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        ran_valid,
	input logic [3:0]  ran_job,
	input logic        segment_start,
	input logic        job_finished,
	input logic [15:0] finish_at,
	input logic [15:0] now_time
);
	`EDFS_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result beat dropped")
	`EDFS_ASSERT_NOW(a_idle, clk, arst_n, out_valid && !ran_valid, ran_job == 4'd0 && !segment_start && !job_finished, "idle result not clean")
	`EDFS_ASSERT_NOW(a_fat0, clk, arst_n, out_valid && !job_finished, finish_at == 16'd0, "finish time without completion")
	`EDFS_ASSERT_NOW(a_fat, clk, arst_n, out_valid && job_finished && now_time != 16'hffff, ran_valid && finish_at == now_time + 16'd1, "finish time mismatch")
endmodule

bind edf_scheduler_with_precedence edfs_checker u_edfs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.ran_valid(results.ran_valid),
	.ran_job(results.ran_job),
	.segment_start(results.segment_start),
	.job_finished(results.job_finished),
	.finish_at(results.finish_at),
	.now_time(results.now_time)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// testbench for edf_scheduler_with_precedence: a directed table and then random job sets,
// each result checked against an in-bench scheduling predictor or a row's typed result
// depends on edfs_pkg, edfs_if and the scheduler rtl
module tb_top;
	typedef struct {
		bit        ran;
		bit [3:0]  job;
		bit        seg;
		bit        fin;
		bit [15:0] fat;
		bit        all_done;
		bit [15:0] now;
	} sched_out_t;

	typedef struct {
		bit         is_cfg;
		bit [1:0]   cmd;
		bit [3:0]   slot;
		bit [14:0]  rel;
		bit [14:0]  work;
		bit [15:0]  due;
		bit [15:0]  mask;
		bit         typed;
		sched_out_t want;
	} stim_row_t;

	localparam int WATCHDOG_CYCLES = 80000;
	localparam int RANDOM_ITEMS    = 1400;
	localparam sched_out_t IDLE_EMPTY = '{0, 0, 0, 0, 0, 1, 0};

	logic clk = 0;
	logic arst_n = 0;

	edfs_cfg_if    cfg();
	edfs_item_if   items();
	edfs_result_if results();

	edf_scheduler_with_precedence u_dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .items(items), .results(results)
	);

	always #2 clk = ~clk;

	// predictor state
	bit [15:0] job_rel[16];
	int        job_due[16];
	int        job_work[16];
	int        job_rem[16];
	bit [15:0] job_pred[16];
	int        job_count_reg;
	int        sched_clock;
	int        last_job;

	sched_out_t outcome_q[$];
	int  mismatches = 0;
	int  sent = 0;
	int  idle_mode = 0;
	int  stall_cycles = 0;

	function automatic void queue_outcome(sched_out_t o);
		outcome_q = {outcome_q, o};
	endfunction

	function automatic int jobs_live();
		return job_count_reg > edfs_pkg::MAX_JOBS ? edfs_pkg::MAX_JOBS : job_count_reg;
	endfunction

	function automatic bit all_finished(int n);
		for (int i = 0; i < n; i++)
			if (job_rem[i] != 0) return 0;
		return 1;
	endfunction

	function automatic bit [15:0] successors(int i, int n);
		bit [15:0] s;
		s = 0;
		for (int j = 0; j < n; j++)
			if (job_pred[j][i]) s[j] = 1;
		return s;
	endfunction

	function automatic void apply_precedence();
		int n;
		bit [15:0] m, fixed, p;
		bit moved;
		int c;
		n = jobs_live();
		m = (n == 16) ? 16'hFFFF : 16'((1 << n) - 1);
		fixed = 0;
		for (int i = 0; i < n; i++)
			if ((job_pred[i] & m) == 0) fixed[i] = 1;
		do begin
			moved = 0;
			for (int i = 0; i < n && !moved; i++) begin
				p = job_pred[i] & m;
				if (fixed[i] || (p & ~fixed) != 0) continue;
				for (int k = 0; k < n; k++)
					if (p[k]) begin
						c = int'(job_rel[k]) + job_work[k];
						if (c > 65535) c = 65535;
						if (c > int'(job_rel[i])) job_rel[i] = 16'(c);
					end
				fixed[i] = 1;
				moved = 1;
			end
		end while (moved);
		fixed = 0;
		for (int i = 0; i < n; i++)
			if (successors(i, n) == 0) fixed[i] = 1;
		do begin
			moved = 0;
			for (int i = 0; i < n && !moved; i++) begin
				p = successors(i, n);
				if (fixed[i] || (p & ~fixed) != 0) continue;
				for (int k = 0; k < n; k++)
					if (p[k]) begin
						c = job_due[k] - job_work[k];
						if (c < -32768) c = -32768;
						if (c < job_due[i]) job_due[i] = c;
					end
				fixed[i] = 1;
				moved = 1;
			end
		end while (moved);
		sched_clock = 0;
		last_job = edfs_pkg::MAX_JOBS;
		for (int i = 0; i < edfs_pkg::MAX_JOBS; i++) job_rem[i] = job_work[i];
	endfunction

	function automatic sched_out_t schedule_step(bit [1:0] cmd, bit [3:0] slot, bit [14:0] rel,
		bit [14:0] work, bit [15:0] due, bit [15:0] mask);
		sched_out_t o;
		int n, pick, best;
		o = '{0, 0, 0, 0, 0, 0, 0};
		n = jobs_live();
		o.now = 16'(sched_clock);
		if (cmd == edfs_pkg::CMD_LOAD) begin
			job_rel[slot]  = {1'b0, rel};
			job_work[slot] = work;
			job_rem[slot]  = work;
			job_due[slot]  = int'($signed(due));
			job_pred[slot] = mask;
		end else if (cmd == edfs_pkg::CMD_PREPARE) begin
			apply_precedence();
			o.now = 16'(sched_clock);
		end else if (cmd == edfs_pkg::CMD_TICK && !all_finished(n)) begin
			pick = edfs_pkg::MAX_JOBS;
			best = 0;
			for (int i = 0; i < n; i++)
				if (job_rem[i] != 0 && int'(job_rel[i]) <= sched_clock &&
					(pick == edfs_pkg::MAX_JOBS || job_due[i] < best)) begin
					pick = i;
					best = job_due[i];
				end
			if (pick == edfs_pkg::MAX_JOBS) begin
				last_job = edfs_pkg::MAX_JOBS;
			end else begin
				o.ran = 1;
				o.job = 4'(pick);
				o.seg = (pick != last_job);
				last_job = pick;
				job_rem[pick]--;
				if (job_rem[pick] == 0) begin
					o.fin = 1;
					o.fat = sched_clock < 65535 ? 16'(sched_clock + 1) : 16'hFFFF;
				end
			end
			if (sched_clock < 65535) sched_clock++;
		end
		o.all_done = all_finished(n);
		return o;
	endfunction

	task automatic send_item(bit [1:0] cmd, bit [3:0] slot, bit [14:0] rel, bit [14:0] work,
		bit [15:0] due, bit [15:0] mask, bit typed = 0, sched_out_t want = IDLE_EMPTY);
		sched_out_t o;
		int gap_pct;
		gap_pct = (idle_mode == 0) ? 10 : (idle_mode == 1) ? 51 : 0;
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			items.valid = 0;
			@(negedge clk);
		end
		items.valid = 1;
		items.cmd = cmd;
		items.job_slot = slot;
		items.release_time = rel;
		items.work_ticks = work;
		items.due_time = due;
		items.predecessor_mask = mask;
		do @(posedge clk); while (!items.ready);
		o = schedule_step(cmd, slot, rel, work, due, mask);
		if (typed) o = want;
		queue_outcome(o);
		sent++;
		idle_mode = sent < 500 ? 0 : sent < 980 ? 1 : 2;
	endtask

	task automatic write_job_count(bit [4:0] value);
		@(negedge clk);
		items.valid = 0;
		wait (outcome_q.size() == 0);
		repeat (20) @(posedge clk);
		@(negedge clk);
		cfg.valid = 1;
		cfg.data = value;
		do @(posedge clk); while (!cfg.ready);
		job_count_reg = value;
		@(negedge clk);
		cfg.valid = 0;
	endtask

	// result side
	always @(negedge clk) begin
		int stall_pct;
		stall_pct = (idle_mode == 0) ? 51 : (idle_mode == 1) ? 10 : 0;
		results.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		sched_out_t w, got;
		if (arst_n && results.valid && results.ready) begin
			got = '{results.ran_valid, results.ran_job, results.segment_start,
				results.job_finished, results.finish_at, results.all_done, results.now_time};
			if (outcome_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %p", got);
			end else begin
				w = outcome_q.pop_front();
				if (got != w) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p got %p", w, got);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((items.valid && items.ready) || (results.valid && results.ready) ||
			(cfg.valid && cfg.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_CYCLES) begin
			$display("FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	stim_row_t directed[$];

	function automatic stim_row_t row(bit is_cfg, bit [1:0] cmd, bit [3:0] slot, bit [14:0] rel,
		bit [14:0] work, bit [15:0] due, bit [15:0] mask, bit typed = 0);
		stim_row_t r;
		r = '{is_cfg, cmd, slot, rel, work, due, mask, typed, IDLE_EMPTY};
		return r;
	endfunction

	function automatic void add_row(stim_row_t r);
		directed = {directed, r};
	endfunction

	initial begin
		bit [1:0]  cmd;
		bit [14:0] rel, work;
		bit [15:0] due, mask;
		int n, ticks, seqs;
		bit [4:0] counts[8] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd8, 5'd3};

		items.valid = 0;
		items.cmd = edfs_pkg::CMD_LOAD;
		items.job_slot = 0;
		items.release_time = 0;
		items.work_ticks = 0;
		items.due_time = 0;
		items.predecessor_mask = 0;
		cfg.valid = 0;
		cfg.data = 0;
		results.ready = 0;
		job_count_reg = 0;
		sched_clock = 0;
		last_job = edfs_pkg::MAX_JOBS;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// empty table: every result idle, all done, time zero
		// config rows carry the count as {cmd[0], slot}
		add_row(row(1, edfs_pkg::CMD_LOAD, 0, 0, 0, 0, 0));
		add_row(row(0, edfs_pkg::CMD_TICK, 0, 0, 0, 0, 0, 1));
		add_row(row(0, edfs_pkg::CMD_UNUSED, 0, 0, 0, 0, 0, 1));
		add_row(row(0, edfs_pkg::CMD_PREPARE, 0, 0, 0, 0, 0, 1));
		add_row(row(0, edfs_pkg::CMD_LOAD, 0, 0, 2, 16'd10, 0, 1));
		add_row(row(0, edfs_pkg::CMD_LOAD, 1, 15'h7FFF, 15'h7FFF, 16'h8000, 16'h0001, 1));
		add_row(row(0, edfs_pkg::CMD_LOAD, 2, 5, 3, 16'h7FFF, 16'h0002, 1));
		add_row(row(0, edfs_pkg::CMD_LOAD, 3, 0, 1, 16'd5, 16'h0008, 1));
		add_row(row(0, edfs_pkg::CMD_LOAD, 4, 0, 0, 0, 16'hFFFF, 1));
		add_row(row(0, edfs_pkg::CMD_LOAD, 5, 3, 1, 16'hFFFB, 0, 1));
		for (int s = 6; s < 16; s++)
			add_row(row(0, edfs_pkg::CMD_LOAD, 4'(s), 1, 0, 16'(s), 0, 1));
		add_row(row(1, edfs_pkg::CMD_LOAD, 6, 0, 0, 0, 0));
		add_row(row(0, edfs_pkg::CMD_PREPARE, 0, 0, 0, 0, 0));
		for (int t = 0; t < 6; t++) add_row(row(0, edfs_pkg::CMD_TICK, 0, 0, 0, 0, 0));
		add_row(row(1, edfs_pkg::CMD_PREPARE, 15, 0, 0, 0, 0));
		add_row(row(0, edfs_pkg::CMD_PREPARE, 0, 0, 0, 0, 0));
		add_row(row(0, edfs_pkg::CMD_TICK, 0, 0, 0, 0, 0));

		foreach (directed[i]) begin
			if (directed[i].is_cfg)
				write_job_count({directed[i].cmd[0], directed[i].slot});
			else
				send_item(directed[i].cmd, directed[i].slot, directed[i].rel, directed[i].work,
					directed[i].due, directed[i].mask, directed[i].typed, directed[i].want);
		end
		write_job_count(5'd31);
		write_job_count(5'd0);
		write_job_count(5'd16);

		// hold off until the directed results are all back
		@(negedge clk);
		items.valid = 0;
		wait (outcome_q.size() == 0);

		sent = 0;
		idle_mode = 0;
		seqs = 0;
		while (sent < RANDOM_ITEMS) begin
			if (seqs % 3 == 0)
				write_job_count(seqs < 24 ? counts[(seqs / 3) % 8] : 5'($urandom_range(31)));
			seqs++;
			n = jobs_live();
			for (int s = 0; s < n; s++) begin
				rel = 15'($urandom_range(6));
				work = 15'($urandom_range(5));
				due = 16'($urandom_range(40)) - 16'd10;
				mask = 16'($urandom) & 16'((1 << s) - 1);
				if ($urandom_range(9) == 0) mask = 16'($urandom);
				if ($urandom_range(19) == 0) begin
					rel = 15'($urandom);
					work = 15'($urandom);
					due = 16'($urandom);
				end
				send_item(edfs_pkg::CMD_LOAD, 4'(s), rel, work, due, mask);
				if ($urandom_range(19) == 0)
					send_item(edfs_pkg::CMD_UNUSED, 4'($urandom), 15'($urandom),
						15'($urandom), 16'($urandom), 16'($urandom));
			end
			send_item(edfs_pkg::CMD_PREPARE, 0, 0, 0, 0, 0);
			ticks = 0;
			while (ticks < 40 && !(all_finished(n) && ticks > 2)) begin
				cmd = ($urandom_range(24) == 0) ? edfs_pkg::CMD_UNUSED : edfs_pkg::CMD_TICK;
				if ($urandom_range(29) == 0) begin
					send_item(edfs_pkg::CMD_LOAD, 4'($urandom_range(15)),
						15'($urandom_range(8)), 15'($urandom_range(4)), 16'($urandom),
						16'($urandom));
				end else begin
					send_item(cmd, 4'($urandom), 15'($urandom), 15'($urandom),
						16'($urandom), 16'($urandom));
				end
				ticks++;
			end
		end

		@(negedge clk);
		items.valid = 0;
		wait (outcome_q.size() == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && outcome_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+design
design/edfs_pkg.sv
design/edfs_if.sv
design/edfs_job_mem.sv
design/edf_scheduler_with_precedence.sv
design/edfs_checker.sv
sim/tb_top.sv
